// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the checker files of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold starting this cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/sat_pkg.sv -----
// Shared types and constants of the section address translator.
package sat_pkg;

	localparam int ADDR_W     = 32;
	localparam int IN_TDATA_W = 168;
	localparam int CFG_IDX_W  = 2;

	// Addresses above this value are rejected in every query mode.
	localparam logic [ADDR_W-1:0] ADDR_LIMIT = 32'h8000_0000;

	// Request modes.
	typedef enum logic [2:0] {
		MODE_LOAD    = 3'd0,
		MODE_RVA2OFF = 3'd1,
		MODE_OFF2RVA = 3'd2,
		MODE_VA2RVA  = 3'd3,
		MODE_RVA2VA  = 3'd4
	} mode_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HEADER_SIZE   = 2'd0,
		CFG_SECTION_COUNT = 2'd1,
		CFG_IMAGE_BASE    = 2'd2
	} cfg_idx_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// One section descriptor as stored in the table.
	typedef struct packed {
		logic [ADDR_W-1:0] raw_size;
		logic [ADDR_W-1:0] raw_ptr;
		logic [ADDR_W-1:0] vsize;
		logic [ADDR_W-1:0] vstart;
	} sect_t;

	// Input request as packed on the stream, lowest field in the lowest bits.
	typedef struct packed {
		logic              pad;
		sect_t             entry;
		logic [3:0]        entry_index;
		logic [ADDR_W-1:0] query_address;
		logic [2:0]        mode;
	} in_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic write_entry;
		logic check;
		logic scan;
		logic push;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_load;
		logic is_query;
		logic early_done;
		logic scan_done;
		logic out_full;
	} dp_status_t;

endpackage

// ----- rtl/core/sat_ctrl.sv -----
// Controller state machine of the section address translator.
module sat_ctrl import sat_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  dp_status_t sts,
	output ctl_cmd_t   cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.is_query) begin
					state_d = sts.early_done ? ST_FINISH : ST_SCAN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!sts.out_full) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs and datapath commands.
	always_comb begin
		cmd           = '0;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.capture   = s_axis_tvalid;
			end
			ST_CHECK: begin
				cmd.write_entry = sts.is_load;
				cmd.check       = sts.is_query;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_FINISH: begin
				cmd.push = !sts.out_full;
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/core/sat_dpath.sv -----
// Datapath of the section address translator: registers, section table and compare logic.
module sat_dpath import sat_pkg::*; #(
	parameter int MAX_SECTIONS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [IN_TDATA_W-1:0]    s_axis_tdata,
	input  logic                     cfg_valid,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [ADDR_W-1:0]        cfg_data,
	input  logic                     m_axis_tready,
	input  ctl_cmd_t                 cmd,
	output dp_status_t               sts,
	output logic                     m_axis_tvalid,
	output logic [ADDR_W-1:0]        m_axis_tdata
);

	localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

	in_item_t          item_q;
	logic [ADDR_W-1:0] header_q;
	logic [4:0]        count_q;
	logic [ADDR_W-1:0] base_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] result_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_data_q;
	sect_t             rd_q;

	sect_t             table_mem [MAX_SECTIONS];

	logic [CNT_W-1:0]  lim;
	logic [CNT_W-1:0]  cnt_nxt;
	logic [IDX_W-1:0]  wr_addr;
	logic [IDX_W-1:0]  rd_addr;
	logic              idx_ok;
	logic [ADDR_W-1:0] addr;
	logic              early_done;
	logic [ADDR_W-1:0] early_res;
	logic              is_rva;
	logic [ADDR_W-1:0] rng_lo;
	logic [ADDR_W-1:0] rng_size;
	logic [ADDR_W-1:0] rng_hi;
	logic [ADDR_W-1:0] dst_base;
	logic              hit;
	logic              no_raw;
	logic [ADDR_W-1:0] scan_res;

	assign addr = item_q.query_address;

	// Capture the request.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_item_t'(s_axis_tdata);
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= '0;
			count_q  <= '0;
			base_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_HEADER_SIZE:   header_q <= cfg_data;
				CFG_SECTION_COUNT: count_q  <= cfg_data[4:0];
				CFG_IMAGE_BASE:    base_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Number of entries to scan, clipped to the table depth.
	assign lim = ({3'b000, count_q} > 8'(MAX_SECTIONS)) ? CNT_W'(MAX_SECTIONS)
		: CNT_W'(count_q);
	assign cnt_nxt = cnt_q + CNT_W'(1);

	// Section table: one write port, one registered read port.
	assign idx_ok  = {4'b0000, item_q.entry_index} < 8'(MAX_SECTIONS);
	assign wr_addr = IDX_W'(item_q.entry_index);
	assign rd_addr = cmd.scan ? cnt_nxt[IDX_W-1:0] : '0;

	always_ff @(posedge clk) begin
		if (cmd.write_entry && idx_ok) begin
			table_mem[wr_addr] <= item_q.entry;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check || cmd.scan) begin
			rd_q <= table_mem[rd_addr];
		end
	end

	// Cases settled without a table scan.
	always_comb begin
		early_done = 1'b1;
		early_res  = '0;
		if (addr <= ADDR_LIMIT) begin
			case (item_q.mode)
				MODE_VA2RVA: begin
					if (addr >= base_q) begin
						early_res = addr - base_q;
					end
				end
				MODE_RVA2VA: begin
					early_res = addr + base_q;
				end
				MODE_RVA2OFF, MODE_OFF2RVA: begin
					if (addr < header_q) begin
						early_res = addr;
					end else if (lim != '0) begin
						early_done = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Range test of the entry read in the previous cycle.
	assign is_rva   = (item_q.mode == MODE_RVA2OFF);
	assign rng_lo   = is_rva ? rd_q.vstart : rd_q.raw_ptr;
	assign rng_size = is_rva ? rd_q.vsize : rd_q.raw_size;
	assign dst_base = is_rva ? rd_q.raw_ptr : rd_q.vstart;
	assign rng_hi   = rng_lo + rng_size;
	assign hit      = (addr >= rng_lo) && (addr < rng_hi);
	assign no_raw   = is_rva && ((rd_q.raw_ptr == '0) || (rd_q.raw_size == '0));
	assign scan_res = no_raw ? '0 : (addr - rng_lo + dst_base);

	// Scan counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.check) begin
			cnt_q <= '0;
		end else if (cmd.scan) begin
			cnt_q <= cnt_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			result_q <= early_res;
		end else if (cmd.scan) begin
			result_q <= hit ? scan_res : '0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_data_q <= result_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Status to the controller.
	assign sts.is_load    = (item_q.mode == MODE_LOAD);
	assign sts.is_query   = item_q.mode inside {MODE_RVA2OFF, MODE_OFF2RVA,
		MODE_VA2RVA, MODE_RVA2VA};
	assign sts.early_done = early_done;
	assign sts.scan_done  = hit || (cnt_nxt == lim);
	assign sts.out_full   = out_valid_q && !m_axis_tready;

endmodule

// ----- rtl/core/section_address_translator.sv -----
// A load passes the capture and check states; a virtual address query passes capture,
// check and finish, and a table query also scans one section entry per cycle (up to
// MAX_SECTIONS) between check and finish; finish stalls while the output is full. The
// block takes one request at a time, and the scan runs through the single table read port.
// Reset clears the controller, the configuration registers and the output valid flag;
// the section table is not cleared and holds no meaning until written.
module section_address_translator import sat_pkg::*; #(
	parameter int MAX_SECTIONS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// mode, query_address, entry_index, entry_virtual_start, entry_virtual_size,
	// entry_raw_pointer, entry_raw_size, one zero pad bit
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// result_address
	output logic [ADDR_W-1:0]     m_axis_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [ADDR_W-1:0]     cfg_data
);

	ctl_cmd_t   cmd;
	dp_status_t sts;

	// Register writes complete at once.
	assign cfg_ready = 1'b1;

	sat_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	sat_dpath #(
		.MAX_SECTIONS (MAX_SECTIONS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.cfg_valid     (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.m_axis_tready (m_axis_tready),
		.cmd           (cmd),
		.sts           (sts),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ----- rtl/core/sat_checker.sv -----
// Port-level assertions of the section address translator and their bind.
`include "assert_macros.svh"

module sat_checker import sat_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [IN_TDATA_W-1:0] s_axis_tdata,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [ADDR_W-1:0]     m_axis_tdata
);

	// A stalled result keeps its value.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

	// The block takes one request at a time.
	`ASSERT_NEXT(a_busy_after_req, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")

	// A new result appears only after the block was busy.
	`ASSERT_IMPLY(a_result_after_work, clk, arst_n, $rose(m_axis_tvalid), $past(!s_axis_tready), "result without work")

	// A load request never produces a result.
	`ASSERT_NEXT(a_load_silent, clk, arst_n, s_axis_tvalid && s_axis_tready && !m_axis_tvalid && (s_axis_tdata[2:0] == MODE_LOAD), !m_axis_tvalid ##1 !m_axis_tvalid, "load produced a result")

	// A relative-to-virtual conversion taken with the output empty passes check and finish straight to a result.
	`ASSERT_IMPLY(a_va_latency, clk, arst_n, s_axis_tvalid && s_axis_tready && !m_axis_tvalid && (s_axis_tdata[2:0] == MODE_RVA2VA), ##3 m_axis_tvalid, "virtual address result late")

endmodule

bind section_address_translator sat_checker u_sat_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ----- tb/tb_section_address_translator.sv -----
// Self-checking testbench for the section address translator: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_section_address_translator import sat_pkg::*;;

	localparam int SECTIONS      = 16;
	localparam int SETTLE_CYCLES = SECTIONS + 8;
	localparam int STALL_LIMIT   = 2000;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 232;

	// Codes that the package does not name.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX    = 2'd3;
	localparam logic [2:0]           MODE_UNUSED_FIRST = 3'd5;
	localparam logic [2:0]           MODE_UNUSED_LAST  = 3'd7;

	typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_kind_t;

	// One line of the directed stimulus.
	typedef struct {
		row_kind_t             kind;
		in_item_t              req;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [ADDR_W-1:0]     reg_val;
		bit                    typed;
		logic [ADDR_W-1:0]     typed_val;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [ADDR_W-1:0]     m_axis_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [ADDR_W-1:0]     cfg_data;

	// Shadow of the block's table and registers, as seen by accepted requests.
	sect_t             sect_shadow [SECTIONS];
	logic [ADDR_W-1:0] cur_header_size;
	logic [4:0]        cur_section_count;
	logic [ADDR_W-1:0] cur_image_base;

	logic [ADDR_W-1:0] pending_results [$];
	logic [ADDR_W-1:0] want_addr;
	dir_row_t          dir_rows [$];
	int                errors;
	int                stalled_cycles;
	bit                quiet;

	section_address_translator #(
		.MAX_SECTIONS(SECTIONS)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Relative address to file offset: first section whose virtual range holds it.
	function automatic logic [ADDR_W-1:0] file_offset_of(input logic [ADDR_W-1:0] a);
		int                n;
		logic [ADDR_W-1:0] vend;
		n = (cur_section_count > SECTIONS) ? SECTIONS : cur_section_count;
		if (a > ADDR_LIMIT) return '0;
		if (a < cur_header_size) return a;
		for (int i = 0; i < n; i++) begin
			vend = sect_shadow[i].vstart + sect_shadow[i].vsize;
			if (a >= sect_shadow[i].vstart && a < vend) begin
				if (sect_shadow[i].raw_ptr == '0 || sect_shadow[i].raw_size == '0) return '0;
				return a - sect_shadow[i].vstart + sect_shadow[i].raw_ptr;
			end
		end
		return '0;
	endfunction

	// File offset to relative address: first section whose raw range holds it.
	function automatic logic [ADDR_W-1:0] rva_of_offset(input logic [ADDR_W-1:0] a);
		int                n;
		logic [ADDR_W-1:0] rend;
		n = (cur_section_count > SECTIONS) ? SECTIONS : cur_section_count;
		if (a > ADDR_LIMIT) return '0;
		if (a < cur_header_size) return a;
		for (int i = 0; i < n; i++) begin
			rend = sect_shadow[i].raw_ptr + sect_shadow[i].raw_size;
			if (a >= sect_shadow[i].raw_ptr && a < rend)
				return a - sect_shadow[i].raw_ptr + sect_shadow[i].vstart;
		end
		return '0;
	endfunction

	// Applies one accepted request to the shadow state; returns 1 when a result is due.
	function automatic bit translate_request(input in_item_t req, output logic [ADDR_W-1:0] res);
		res = '0;
		case (req.mode)
		MODE_LOAD: begin
			sect_shadow[req.entry_index] = req.entry;
			return 1'b0;
		end
		MODE_RVA2OFF: res = file_offset_of(req.query_address);
		MODE_OFF2RVA: res = rva_of_offset(req.query_address);
		MODE_VA2RVA: begin
			if (req.query_address > ADDR_LIMIT || req.query_address < cur_image_base) res = '0;
			else res = req.query_address - cur_image_base;
		end
		MODE_RVA2VA: begin
			if (req.query_address > ADDR_LIMIT) res = '0;
			else res = req.query_address + cur_image_base;
		end
		default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic in_item_t query_req(input logic [2:0] m, input logic [ADDR_W-1:0] a);
		in_item_t it;
		it = '0;
		it.mode = m;
		it.query_address = a;
		return it;
	endfunction

	function automatic in_item_t load_req(input logic [3:0] idx, input sect_t s);
		in_item_t it;
		it = '0;
		it.mode = MODE_LOAD;
		it.entry_index = idx;
		it.entry = s;
		return it;
	endfunction

	function automatic dir_row_t row_req(input in_item_t req, input bit typed,
			input logic [ADDR_W-1:0] val);
		dir_row_t row;
		row.kind = ROW_REQUEST;
		row.req = req;
		row.reg_idx = '0;
		row.reg_val = '0;
		row.typed = typed;
		row.typed_val = val;
		return row;
	endfunction

	function automatic dir_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [ADDR_W-1:0] val);
		dir_row_t row;
		row = row_req('0, 1'b0, '0);
		row.kind = ROW_CONFIG;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	// Appends one line to the directed stimulus.
	function automatic void add_row(input dir_row_t row);
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	// Random section descriptor: mostly plausible sections, some degenerate or wild.
	function automatic sect_t make_section();
		sect_t s;
		int    r;
		r = $urandom_range(0, 99);
		s.vstart   = $urandom_range(0, 32'h7FFF_0000) & 32'hFFFF_F000;
		s.vsize    = $urandom_range(1, 32'h1_0000);
		s.raw_ptr  = $urandom_range(1, 32'h7FFF_0000);
		s.raw_size = $urandom_range(1, 32'h1_0000);
		if (r < 20) begin
			// Overlap an existing section so that index order decides.
			s.vstart  = sect_shadow[$urandom_range(0, SECTIONS - 1)].vstart + $urandom_range(0, 32'h800);
			s.raw_ptr = sect_shadow[$urandom_range(0, SECTIONS - 1)].raw_ptr + $urandom_range(0, 32'h800);
		end else if (r < 30) begin
			if ($urandom_range(0, 1)) s.raw_ptr = '0;
			else s.raw_size = '0;
		end else if (r < 38) begin
			// Ranges whose end wraps past the top of the address space.
			s.vstart   = 32'hFFFF_0000 | $urandom_range(0, 32'hFFFF);
			s.vsize    = $urandom_range(32'h1_0000, 32'h2_0000);
			s.raw_ptr  = 32'h7FFF_0000 | $urandom_range(0, 32'hFFFF);
			s.raw_size = $urandom();
		end else if (r < 42) begin
			s.vsize = '0;
		end else if (r < 55) begin
			s.vstart   = $urandom();
			s.vsize    = $urandom();
			s.raw_ptr  = $urandom();
			s.raw_size = $urandom();
		end
		return s;
	endfunction

	// Random query, mostly aimed at section edges, the header range and the address limit.
	function automatic in_item_t make_query();
		logic [2:0]        m;
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] span;
		logic [ADDR_W-1:0] a;
		int                r;
		int                k;
		r = $urandom_range(0, 99);
		if (r < 35) m = MODE_RVA2OFF;
		else if (r < 70) m = MODE_OFF2RVA;
		else if (r < 85) m = MODE_VA2RVA;
		else m = MODE_RVA2VA;
		k = $urandom_range(0, SECTIONS - 1);
		start = (m == MODE_OFF2RVA) ? sect_shadow[k].raw_ptr : sect_shadow[k].vstart;
		span  = (m == MODE_OFF2RVA) ? sect_shadow[k].raw_size : sect_shadow[k].vsize;
		if (m == MODE_VA2RVA) begin
			start = cur_image_base;
			span  = 32'h10_0000;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			case ($urandom_range(0, 4))
			0: a = start;
			1: a = start + span - 1;
			2: a = start + span;
			3: a = start - 1;
			default: a = start + ((span == '0) ? '0 : ($urandom() % span));
			endcase
		end else if (r < 72) begin
			a = cur_header_size + $urandom_range(0, 2) - 1;
		end else if (r < 84) begin
			a = ADDR_LIMIT + $urandom_range(0, 3) - 2;
		end else begin
			a = $urandom();
		end
		return query_req(m, a);
	endfunction

	// Offers one request after a random gap and records its expected result once accepted.
	task automatic send_request(input in_item_t req, input bit typed,
			input logic [ADDR_W-1:0] typed_val);
		int                gap;
		logic [ADDR_W-1:0] res;
		gap = idle_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= req;
		do @(posedge clk); while (!s_axis_tready);
		if (translate_request(req, res))
			pending_results.insert(pending_results.size(), typed ? typed_val : res);
	endtask

	// Stops offering requests and waits until the block has gone quiet.
	task automatic drain_and_settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		CFG_HEADER_SIZE:   cur_header_size = val;
		CFG_SECTION_COUNT: cur_section_count = val[4:0];
		CFG_IMAGE_BASE:    cur_image_base = val;
		default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Result checker: every accepted result against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result_address, expected none, actual %h",
					$time, m_axis_tdata);
				errors++;
			end else begin
				want_addr = pending_results.pop_front();
				if (m_axis_tdata !== want_addr) begin
					$display("%0t: result_address mismatch, expected %h, actual %h",
						$time, want_addr, m_axis_tdata);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles in which no channel moves anything.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready)) begin
				stalled_cycles <= 0;
			end else if (stalled_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("TB_ERROR");
				$finish;
			end else begin
				stalled_cycles <= stalled_cycles + 1;
			end
		end
	end

	// Result-side back-pressure.
	initial begin
		int g;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			g = idle_gap();
			if (g > 0) begin
				m_axis_tready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	initial begin
		in_item_t          it;
		int                counted;
		int                r;
		logic [ADDR_W-1:0] hdr;
		logic [ADDR_W-1:0] base;
		logic [4:0]        cnt;

		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		m_axis_tready  = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		errors         = 0;
		stalled_cycles = 0;
		quiet          = 1'b0;
		cur_header_size   = '0;
		cur_section_count = '0;
		cur_image_base    = '0;
		foreach (sect_shadow[i]) sect_shadow[i] = '0;

		// Directed stimulus. Typed results are the ones obvious by inspection.
		// Empty table, zero registers, address limit edges.
		add_row(row_req(query_req(MODE_RVA2OFF, 32'h0000_1000), 1'b1, '0));
		add_row(row_req(query_req(MODE_RVA2VA, 32'h0000_1234), 1'b1, 32'h0000_1234));
		add_row(row_req(query_req(MODE_VA2RVA, 32'h8000_0001), 1'b1, '0));
		add_row(row_req(query_req(MODE_RVA2VA, 32'hFFFF_FFFF), 1'b1, '0));
		add_row(row_req(query_req(MODE_RVA2VA, ADDR_LIMIT), 1'b1, ADDR_LIMIT));
		// Four sections: an overlap, one without raw data, one with a wrapped virtual end.
		add_row(row_req(load_req(4'd0, '{32'h0000_1800, 32'h0000_0400,
			32'h0000_2000, 32'h0000_1000}), 1'b0, '0));
		add_row(row_req(load_req(4'd1, '{32'h0000_0200, 32'h0000_3000,
			32'h0000_1000, 32'h0000_2000}), 1'b0, '0));
		add_row(row_req(load_req(4'd2, '{32'h0000_0100, 32'h0000_0000,
			32'h0000_1000, 32'h0000_5000}), 1'b0, '0));
		add_row(row_req(load_req(4'd3, '{32'h0000_0200, 32'h7FFF_FF00,
			32'h0000_2000, 32'hFFFF_F000}), 1'b0, '0));
		add_row(row_cfg(CFG_HEADER_SIZE, 32'h0000_0400));
		add_row(row_cfg(CFG_SECTION_COUNT, 32'h0000_0004));
		add_row(row_cfg(CFG_IMAGE_BASE, 32'h0040_0000));
		add_row(row_cfg(CFG_UNUSED_IDX, 32'hFFFF_FFFF));
		add_row(row_req(query_req(MODE_RVA2OFF, 32'h0000_03FF), 1'b1, 32'h0000_03FF));
		add_row(row_req(query_req(MODE_OFF2RVA, 32'h0000_0000), 1'b1, '0));
		add_row(row_req(query_req(MODE_RVA2OFF, 32'h0000_2100), 1'b0, '0));
		add_row(row_req(query_req(MODE_RVA2OFF, 32'h0000_5010), 1'b1, '0));
		add_row(row_req(query_req(MODE_RVA2OFF, 32'h0000_9000), 1'b1, '0));
		add_row(row_req(query_req(MODE_OFF2RVA, 32'h0000_3010), 1'b0, '0));
		add_row(row_req(query_req(MODE_OFF2RVA, ADDR_LIMIT), 1'b0, '0));
		add_row(row_req(query_req(MODE_OFF2RVA, 32'h8000_0001), 1'b1, '0));
		add_row(row_req(query_req(MODE_VA2RVA, 32'h003F_FFFF), 1'b1, '0));
		add_row(row_req(query_req(MODE_VA2RVA, ADDR_LIMIT), 1'b0, '0));
		// Unused modes give nothing back.
		add_row(row_req(query_req(MODE_UNUSED_FIRST, 32'h0000_1000), 1'b0, '0));
		add_row(row_req(query_req(3'(MODE_UNUSED_FIRST + 1), 32'hFFFF_FFFF), 1'b0, '0));
		add_row(row_req(query_req(MODE_UNUSED_LAST, 32'h0000_2100), 1'b0, '0));
		// Register extremes: everything is header, and the base wraps sums.
		add_row(row_cfg(CFG_HEADER_SIZE, 32'hFFFF_FFFF));
		add_row(row_cfg(CFG_IMAGE_BASE, 32'hFFFF_FFFF));
		add_row(row_req(query_req(MODE_RVA2OFF, 32'h1234_5678), 1'b1, 32'h1234_5678));
		add_row(row_req(query_req(MODE_RVA2VA, 32'h0000_0001), 1'b1, '0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CONFIG) begin
				drain_and_settle();
				write_register(dir_rows[i].reg_idx, dir_rows[i].reg_val);
			end else begin
				send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].typed_val);
			end
		end

		// Fill the whole table before any scan can reach the upper entries.
		for (int i = 0; i < SECTIONS; i++)
			send_request(load_req(4'(i), make_section()), 1'b0, '0);

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_and_settle();
			quiet = (ph % 3 == 2);
			case (ph)
			0: begin
				hdr  = '0;
				cnt  = 5'(SECTIONS);
				base = '0;
			end
			1: begin
				hdr  = 32'hFFFF_FFFF;
				cnt  = 5'd31;
				base = 32'hFFFF_FFFF;
			end
			2: begin
				hdr  = 32'h0000_0200;
				cnt  = 5'd0;
				base = 32'h0040_0000;
			end
			default: begin
				r = $urandom_range(0, 3);
				hdr  = (r == 0) ? '0 : (r == 3) ? $urandom() : $urandom_range(1, 32'h2000);
				cnt  = 5'($urandom_range(0, 31));
				r = $urandom_range(0, 3);
				base = (r == 0) ? 32'h0040_0000 : (r == 1) ? 32'h1000_0000 : $urandom();
			end
			endcase
			write_register(CFG_HEADER_SIZE, hdr);
			write_register(CFG_SECTION_COUNT, ($urandom() & 32'hFFFF_FFE0) | cnt);
			write_register(CFG_IMAGE_BASE, base);
			if ($urandom_range(0, 1)) write_register(CFG_UNUSED_IDX, $urandom());

			counted = 0;
			while (counted < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 4) begin
					// Unused mode with random content.
					it = load_req(4'($urandom_range(0, SECTIONS - 1)), make_section());
					it.mode = 3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
					it.query_address = $urandom();
					send_request(it, 1'b0, '0);
				end else if (r < 14) begin
					send_request(load_req(4'($urandom_range(0, SECTIONS - 1)), make_section()),
						1'b0, '0);
					counted++;
				end else begin
					send_request(make_query(), 1'b0, '0);
					counted++;
				end
			end
		end

		drain_and_settle();
		if (errors == 0 && pending_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
